### rtl/fur_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fur_pkg;

  // Field widths that do not follow the coordinate parameter
  localparam int DefCoordBits = 12;
  localparam int FocalBits    = 16;
  localparam int GainBits     = 16;
  localparam int CfgIdxBits   = 3;
  localparam int CfgDataBits  = 16;
  localparam int DenShift     = 10;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxBits-1:0] {
    RegWidth  = 3'd0,
    RegHeight = 3'd1,
    RegCentreX = 3'd2,
    RegCentreY = 3'd3,
    RegFocal  = 3'd4,
    RegGain   = 3'd5
  } cfg_reg_e;

  localparam logic [FocalBits-1:0] FocalReset = 16'd16;
  localparam logic [GainBits-1:0]  GainReset  = 16'd16384;

endpackage

`default_nettype wire

### rtl/fur_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Destination pixel channel
interface fur_in_if #(
  parameter int CW = 12
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] dest_col;
  logic [CW-1:0] dest_row;

  modport source (output valid, output dest_col, output dest_row, input ready);
  modport sink   (input valid, input dest_col, input dest_row, output ready);
endinterface

// Source pixel channel
interface fur_out_if #(
  parameter int CW = 12
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] source_col;
  logic [CW-1:0] source_row;
  logic          in_range;

  modport source (output valid, output source_col, output source_row,
                  output in_range, input ready);
  modport sink   (input valid, input source_col, input source_row,
                  input in_range, output ready);
endinterface

// Configuration write channel
interface fur_cfg_if;
  import fur_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/fur_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, one root bit per stage
module fur_isqrt #(
  parameter int SW  = 42,
  parameter int DW  = 21,
  parameter int SBW = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [SW-1:0]  sq_i,
  input  wire logic [SBW-1:0] side_i,
  output logic                valid_o,
  output logic [DW-1:0]       root_o,
  output logic [SBW-1:0]      side_o
);

  localparam int RW = SW + 2;

  logic           v_q    [DW+1];
  logic [RW-1:0]  rem_q  [DW+1];
  logic [DW-1:0]  res_q  [DW+1];
  logic [SBW-1:0] side_q [DW+1];

  // Stage zero is the input itself
  always_comb begin
    v_q[0]    = valid_i;
    rem_q[0]  = RW'(sq_i);
    res_q[0]  = '0;
    side_q[0] = side_i;
  end

  for (genvar k = 0; k < DW; k++) begin : g_stage
    localparam int Bit = DW - 1 - k;
    logic [RW-1:0] diff;
    logic          take;

    // Trial value (res + 2^bit)^2 - res^2
    assign diff = (RW'(res_q[k]) << (Bit + 1)) + (RW'(1) << (2 * Bit));
    assign take = rem_q[k] >= diff;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? rem_q[k] - diff : rem_q[k];
        res_q[k+1]  <= take ? (res_q[k] | (DW'(1) << Bit)) : res_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[DW];
  assign root_o  = res_q[DW];
  assign side_o  = side_q[DW];

endmodule

`default_nettype wire

### rtl/fur_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage
module fur_div #(
  parameter int NW  = 44,
  parameter int DVW = 31,
  parameter int QW  = 14,
  parameter int SBW = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [NW-1:0]  num_i,
  input  wire logic [DVW-1:0] den_i,
  input  wire logic [SBW-1:0] side_i,
  output logic                valid_o,
  output logic [QW-1:0]       quot_o,
  output logic                rem_nz_o,
  output logic [SBW-1:0]      side_o
);

  localparam int WW = (NW > DVW + QW) ? NW : DVW + QW;

  logic           v_q    [QW+1];
  logic [WW-1:0]  rem_q  [QW+1];
  logic [DVW-1:0] den_q  [QW+1];
  logic [QW-1:0]  quo_q  [QW+1];
  logic [SBW-1:0] side_q [QW+1];

  always_comb begin
    v_q[0]    = valid_i;
    rem_q[0]  = WW'(num_i);
    den_q[0]  = den_i;
    quo_q[0]  = '0;
    side_q[0] = side_i;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int Bit = QW - 1 - k;
    logic [WW-1:0] dsh;
    logic          take;

    // Subtract the shifted divisor where it fits
    assign dsh  = WW'(den_q[k]) << Bit;
    assign take = rem_q[k] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? rem_q[k] - dsh : rem_q[k];
        den_q[k+1]  <= den_q[k];
        quo_q[k+1]  <= take ? (quo_q[k] | (QW'(1) << Bit)) : quo_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o  = v_q[QW];
  assign quot_o   = quo_q[QW];
  assign rem_nz_o = rem_q[QW] != '0;
  assign side_o   = side_q[QW];

endmodule

`default_nettype wire

### rtl/fisheye_undistort_remap.sv
`timescale 1ns / 1ps
`default_nettype none

// Fisheye undistortion remap address generator. Each destination pixel
// transfer gives one source pixel transfer, in order, one per clock when the
// output is not stalled. The radius square root has R root bits (21 at
// 12-bit coordinates) and the offset divide has Q = COORD_BITS + 2 quotient
// bits: both are bit-per-stage pipelines. The whole pipeline holds while a
// result waits. Configuration writes are taken at any time and must be made
// only while the pipeline is empty.
module fisheye_undistort_remap #(
  parameter int COORD_BITS = fur_pkg::DefCoordBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fur_cfg_if.sink   cfg_if,
  fur_in_if.sink    in_if,
  fur_out_if.source out_if
);

  import fur_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int SQW = 2 * C + 17;
  localparam int SW  = ((SQW > 40) ? SQW : 40) + 1;
  localparam int DW  = (SW + 1) / 2;
  localparam int DVW = DW + DenShift;
  localparam int NW  = C + GainBits + FocalBits;
  localparam int QW  = C + 2;
  localparam int MGW = C + GainBits;
  localparam int XW  = C + 4;
  localparam int ISB = 4 + 2 * NW;

  // Configuration registers
  logic [C-1:0]         width_q, height_q, cx_q, cy_q;
  logic [FocalBits-1:0] focal_q;
  logic [GainBits-1:0]  gain_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      focal_q  <= FocalReset;
      gain_q   <= GainReset;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        RegWidth:   width_q  <= cfg_if.data[C-1:0];
        RegHeight:  height_q <= cfg_if.data[C-1:0];
        RegCentreX: cx_q     <= cfg_if.data[C-1:0];
        RegCentreY: cy_q     <= cfg_if.data[C-1:0];
        RegFocal:   focal_q  <= cfg_if.data;
        RegGain:    gain_q   <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Pipeline advance: hold everything while the output waits
  logic en;
  logic out_v_q;
  assign en          = !out_v_q || out_if.ready;
  assign in_if.ready = en;

  // Stage 0: offsets from the centre
  logic         v0_q, sx0_q, sy0_q;
  logic [C-1:0] mx0_q, my0_q;
  logic [C:0]   dx, dy;

  assign dx = {1'b0, in_if.dest_col} - {1'b0, cx_q};
  assign dy = {1'b0, in_if.dest_row} - {1'b0, cy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx0_q <= dx[C];
      sy0_q <= dy[C];
      mx0_q <= dx[C] ? C'(-dx) : dx[C-1:0];
      my0_q <= dy[C] ? C'(-dy) : dy[C-1:0];
    end
  end

  // Stage 1: squares and gain products
  logic                   v1_q, sx1_q, sy1_q, zx1_q, zy1_q;
  logic [2*C-1:0]         qx1_q, qy1_q;
  logic [MGW-1:0]         gx1_q, gy1_q;
  logic [2*FocalBits-1:0] ff1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx1_q <= sx0_q;
      sy1_q <= sy0_q;
      zx1_q <= mx0_q == '0;
      zy1_q <= my0_q == '0;
      qx1_q <= (2*C)'(mx0_q) * (2*C)'(mx0_q);
      qy1_q <= (2*C)'(my0_q) * (2*C)'(my0_q);
      gx1_q <= MGW'(mx0_q) * MGW'(gain_q);
      gy1_q <= MGW'(my0_q) * MGW'(gain_q);
      ff1_q <= (2*FocalBits)'(focal_q) * (2*FocalBits)'(focal_q);
    end
  end

  // Stage 2: squared radius and full numerators
  logic          v2_q, sx2_q, sy2_q, zx2_q, zy2_q;
  logic [SW-1:0] s2_q;
  logic [NW-1:0] nx2_q, ny2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx2_q <= sx1_q;
      sy2_q <= sy1_q;
      zx2_q <= zx1_q;
      zy2_q <= zy1_q;
      s2_q  <= ((SW'(qx1_q) + SW'(qy1_q)) << 16) + (SW'(ff1_q) << 8);
      nx2_q <= NW'(gx1_q) * NW'(focal_q);
      ny2_q <= NW'(gy1_q) * NW'(focal_q);
    end
  end

  // Radius square root
  logic           vr;
  logic [DW-1:0]  root;
  logic [ISB-1:0] rside;

  fur_isqrt #(
    .SW  (SW),
    .DW  (DW),
    .SBW (ISB)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .sq_i    (s2_q),
    .side_i  ({sx2_q, sy2_q, zx2_q, zy2_q, nx2_q, ny2_q}),
    .valid_o (vr),
    .root_o  (root),
    .side_o  (rside)
  );

  logic          r_sx, r_sy, r_zx, r_zy, r_dz;
  logic [NW-1:0] r_nx, r_ny;
  logic [DVW-1:0] den;

  assign {r_sx, r_sy, r_zx, r_zy, r_nx, r_ny} = rside;
  assign r_dz = root == '0;
  assign den  = {root, DenShift'(0)};

  // Offset divides, one per axis
  logic          vx, vy, rnx, rny;
  logic [QW-1:0] qx, qy;
  logic [1:0]    sdx, sdy;

  fur_div #(.NW(NW), .DVW(DVW), .QW(QW), .SBW(2)) u_div_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (vr),
    .num_i    (r_nx),
    .den_i    (den),
    .side_i   ({r_sx, r_zx | r_dz}),
    .valid_o  (vx),
    .quot_o   (qx),
    .rem_nz_o (rnx),
    .side_o   (sdx)
  );

  fur_div #(.NW(NW), .DVW(DVW), .QW(QW), .SBW(2)) u_div_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (vr),
    .num_i    (r_ny),
    .den_i    (den),
    .side_i   ({r_sy, r_zy | r_dz}),
    .valid_o  (vy),
    .quot_o   (qy),
    .rem_nz_o (rny),
    .side_o   (sdy)
  );

  // Final stage: add offsets to the centre, truncate toward zero, range check
  function automatic logic signed [XW-1:0] axis_sum(
    input logic [C-1:0]  centre,
    input logic [QW-1:0] fl,
    input logic          rem_nz,
    input logic          neg,
    input logic          zero
  );
    logic signed [XW-1:0] c, f, fr;
    c  = XW'(centre);
    f  = XW'(fl);
    fr = f + XW'(rem_nz);
    if (zero) begin
      return c;
    end else if (!neg) begin
      return c + f;
    end else if (c >= fr) begin
      return c - fr;
    end else begin
      return c - f;
    end
  endfunction

  logic signed [XW-1:0] sx, sy;
  logic                 ok;

  assign sx = axis_sum(cx_q, qx, rnx, sdx[1], sdx[0]);
  assign sy = axis_sum(cy_q, qy, rny, sdy[1], sdy[0]);
  assign ok = (sx >= 0) && (sy >= 0) &&
              (sx < $signed(XW'(width_q))) && (sy < $signed(XW'(height_q)));

  logic [C-1:0] col_q, row_q;
  logic         rng_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vx & vy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      col_q <= ok ? sx[C-1:0] : '0;
      row_q <= ok ? sy[C-1:0] : '0;
      rng_q <= ok;
    end
  end

  assign out_if.valid      = out_v_q;
  assign out_if.source_col = col_q;
  assign out_if.source_row = row_q;
  assign out_if.in_range   = rng_q;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fur_pkg::*;

  localparam int CW         = 12;
  localparam int PipeDepth  = 4 + 21 + CW + 2;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    logic          in_range;
  } src_pixel_t;

  typedef struct packed {
    logic [CW-1:0] col;
    logic [CW-1:0] row;
  } dest_pixel_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fur_cfg_if         cfg_bus ();
  fur_in_if  #(.CW(CW)) in_bus ();
  fur_out_if #(.CW(CW)) out_bus ();

  fisheye_undistort_remap #(.COORD_BITS(CW)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_bus),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the lens and image settings
  logic [CW-1:0]        img_w, img_h, ctr_x, ctr_y;
  logic [FocalBits-1:0] focal;
  logic [GainBits-1:0]  gain;

  dest_pixel_t pixel_q[$];
  src_pixel_t  remap_q[$];
  int unsigned errors     = 0;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned cycles     = 0;
  logic        in_taken   = 1'b0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Source position on one axis, truncated toward zero
  function automatic longint warp_axis(longint ctr, longint d, longint unsigned den);
    longint unsigned mag, num, q, r;
    if (d == 0 || den == 0) return ctr;
    mag = (d < 0) ? -d : d;
    num = mag * longint'(gain) * longint'(focal);
    q   = num / den;
    r   = num % den;
    if (d > 0) return ctr + longint'(q);
    if (ctr >= longint'(q + (r != 0))) return ctr - longint'(q) - longint'(r != 0);
    return ctr - longint'(q);
  endfunction

  function automatic src_pixel_t undistort(dest_pixel_t p);
    longint rx, ry, sx, sy;
    longint unsigned rsq, den;
    src_pixel_t res;
    rx  = longint'(p.col) - longint'(ctr_x);
    ry  = longint'(p.row) - longint'(ctr_y);
    rsq = (rx * rx + ry * ry) * 65536 + longint'(focal) * longint'(focal) * 256;
    den = root_floor(rsq) * 1024;
    sx  = warp_axis(longint'(ctr_x), rx, den);
    sy  = warp_axis(longint'(ctr_y), ry, den);
    res.in_range = (sx >= 0 && sy >= 0 && sx < longint'(img_w) && sy < longint'(img_h));
    res.col = res.in_range ? sx[CW-1:0] : '0;
    res.row = res.in_range ? sy[CW-1:0] : '0;
    return res;
  endfunction

  // Track settings, predict on each input transfer, check each output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w <= '0; img_h <= '0; ctr_x <= '0; ctr_y <= '0;
      focal <= FocalReset; gain <= GainReset;
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_bus.valid && in_bus.ready;
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_reg_e'(cfg_bus.index))
          RegWidth:   img_w <= cfg_bus.data[CW-1:0];
          RegHeight:  img_h <= cfg_bus.data[CW-1:0];
          RegCentreX: ctr_x <= cfg_bus.data[CW-1:0];
          RegCentreY: ctr_y <= cfg_bus.data[CW-1:0];
          RegFocal:   focal <= cfg_bus.data;
          RegGain:    gain  <= cfg_bus.data;
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready)
        remap_q.push_back(undistort('{col: in_bus.dest_col, row: in_bus.dest_row}));
      if (out_bus.valid && out_bus.ready) begin
        if (remap_q.size() == 0) begin
          $display("%0t: unexpected result col=%0d row=%0d in_range=%0b", $time,
                   out_bus.source_col, out_bus.source_row, out_bus.in_range);
          errors++;
        end else begin
          src_pixel_t exp_px;
          exp_px = remap_q.pop_front();
          if (out_bus.source_col !== exp_px.col) begin
            $display("%0t: source_col expected %0d got %0d", $time, exp_px.col,
                     out_bus.source_col);
            errors++;
          end
          if (out_bus.source_row !== exp_px.row) begin
            $display("%0t: source_row expected %0d got %0d", $time, exp_px.row,
                     out_bus.source_row);
            errors++;
          end
          if (out_bus.in_range !== exp_px.in_range) begin
            $display("%0t: in_range expected %0b got %0b", $time, exp_px.in_range,
                     out_bus.in_range);
            errors++;
          end
        end
      end
    end
  end

  // Feed destination pixels, idling at random; stall the output at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_bus.valid || in_taken) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          dest_pixel_t p;
          p = pixel_q.pop_front();
          in_bus.valid    <= 1'b1;
          in_bus.dest_col <= p.col;
          in_bus.dest_row <= p.row;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Give up on a hung pipeline
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("fisheye_undistort_remap verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, int val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val[CfgDataBits-1:0];
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_lens(int w, int h, int cx, int cy, int f, int g);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegCentreX, cx);
    write_reg(RegCentreY, cy);
    write_reg(RegFocal, f);
    write_reg(RegGain, g);
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || in_bus.valid || remap_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 5) @(posedge clk_i);
  endtask

  task automatic add_pixel(int c, int r);
    pixel_q.push_back('{col: c[CW-1:0], row: r[CW-1:0]});
  endtask

  // Mostly inside the image or near the centre, some anywhere
  task automatic add_random_pixel();
    case ($urandom_range(3))
      0: add_pixel($urandom_range(4095), $urandom_range(4095));
      3: add_pixel(int'(ctr_x) + $urandom_range(16) - 8, int'(ctr_y) + $urandom_range(16) - 8);
      default: begin
        if (img_w != 0 && img_h != 0)
          add_pixel($urandom_range(img_w - 1), $urandom_range(img_h - 1));
        else
          add_pixel($urandom_range(4095), $urandom_range(4095));
      end
    endcase
  endtask

  task automatic set_mode(int m);
    case (m % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 73; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 73; end
      default: begin idle_pct = 7; stall_pct = 7; end
    endcase
  endtask

  initial begin
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = '0;
    cfg_bus.data    = '0;
    in_bus.valid    = 1'b0;
    in_bus.dest_col = '0;
    in_bus.dest_row = '0;
    out_bus.ready   = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: zero image size, nothing in range
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(100, 37);
    drain();

    // Typical lens: centre pixel, corners and edges
    set_lens(640, 480, 320, 240, 300 << 4, 16384);
    add_pixel(320, 240);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(0, 4095);
    add_pixel(4095, 0);
    add_pixel(639, 479);
    add_pixel(321, 240);
    add_pixel(319, 239);
    drain();

    // Zero gain collapses onto the centre
    write_reg(RegGain, 0);
    add_pixel(0, 0);
    add_pixel(4095, 17);
    add_pixel(320, 240);
    drain();

    // Extremes: largest settings, then the smallest focal length
    set_lens(4095, 4095, 4095, 0, 65535, 65535);
    add_pixel(0, 4095);
    add_pixel(4095, 0);
    add_pixel(2048, 2048);
    drain();
    write_reg(RegFocal, 1);
    add_pixel(4094, 1);
    add_pixel(0, 4095);
    add_pixel(4095, 0);
    add_pixel(1000, 3000);
    drain();

    // Random settings and pixels, cycling through the handshake modes
    for (int ph = 0; ph < 8; ph++) begin
      int w, h;
      w = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(64, 1024);
      h = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(64, 1024);
      set_lens(w, h,
               (w != 0) ? $urandom_range(w) : $urandom_range(4095),
               (h != 0) ? $urandom_range(h) : $urandom_range(4095),
               $urandom_range(1) ? $urandom_range(1, 65535) : $urandom_range(16, 8000),
               $urandom_range(1) ? $urandom_range(65535) : $urandom_range(8000, 24000));
      set_mode(ph);
      @(posedge clk_i);
      for (int k = 0; k < 60; k++) add_random_pixel();
      // Hold off the sender until the pipeline has emptied
      if (ph == 2)
        while (pixel_q.size() != 0 || in_bus.valid || remap_q.size() != 0) @(posedge clk_i);
      for (int k = 0; k < 55; k++) add_random_pixel();
      drain();
    end

    set_mode(0);
    if (errors == 0)
      $display("fisheye_undistort_remap verification clean");
    else
      $display("fisheye_undistort_remap verification failed");
    $finish;
  end

endmodule
